[sv/svpwm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared widths, constants and sine polynomial for the space vector duty pipe
// ----------------------------------------------------------------------------
package svpwm_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int SINE_DEPTH_DEF = 256;

   localparam int DATA_W  = 16;
   localparam int SIN_W   = 18;
   localparam int PROD_W  = 34;
   localparam int AMAG_W  = 25;
   localparam int SQ_W    = 50;
   localparam int ROOT_W  = SQ_W / 2;
   localparam int NUM_W   = ROOT_W + 8;
   localparam int K_W     = 17;
   localparam int T_W     = 17;
   localparam int SUM_W   = 18;
   localparam int TA_W    = 18;
   localparam int SECT_W  = 3;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_SUPPLY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD = 1'd1;

   localparam logic [DATA_W-1:0] SUPPLY_RESET = 16'd1200;
   localparam logic [DATA_W-1:0] PERIOD_RESET = 16'd100;

   localparam logic [DATA_W-1:0] UREF_MAX  = 16'd37814;
   localparam logic [K_W-1:0]    SQRT3_Q16 = 17'd113512;

   localparam logic [SECT_W-1:0] SECT_1 = 3'd1;
   localparam logic [SECT_W-1:0] SECT_2 = 3'd2;
   localparam logic [SECT_W-1:0] SECT_3 = 3'd3;
   localparam logic [SECT_W-1:0] SECT_4 = 3'd4;
   localparam logic [SECT_W-1:0] SECT_5 = 3'd5;
   localparam logic [SECT_W-1:0] SECT_6 = 3'd6;

   localparam longint Q30_ONE = 64'sd1073741824;
   localparam longint POLY_COEF [5] = '{
      64'sd1686629713, -64'sd693598668, 64'sd85569305, -64'sd5026992, 64'sd172273
   };

   // items carried alongside the magnitude and divider pipes
   typedef struct packed {
      logic [K_W-1:0]    k1;
      logic [K_W-1:0]    k2;
      logic [SECT_W-1:0] sector;
   } svpwm_side_type;

   function automatic longint qmul30(input longint a, input longint b);
      return (a * b) / Q30_ONE;
   endfunction

   // quarter wave sine, q30 argument, q16 result
   function automatic longint quarter_sine(input longint u);
      longint u2;
      longint acc;
      u2  = qmul30(u, u);
      acc = POLY_COEF[4];
      for (int k = 3; k >= 0; k--) begin
         acc = POLY_COEF[k] + qmul30(acc, u2);
      end
      acc = qmul30(acc, u);
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > Q30_ONE) begin
         acc = Q30_ONE;
      end
      return (acc + 64'sd8192) >>> 14;
   endfunction

endpackage

[sv/svpwm_sine_rom.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_sine_rom
// Full turn sine table with two registered read ports
// ----------------------------------------------------------------------------
module svpwm_sine_rom #(
   parameter int SINE_TABLE_DEPTH = svpwm_pkg::SINE_DEPTH_DEF
) (
   input  logic clock,
   input  logic en,
   input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr_a,
   input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr_b,
   output logic signed [svpwm_pkg::SIN_W-1:0] data_a_ff,
   output logic signed [svpwm_pkg::SIN_W-1:0] data_b_ff
);

   logic signed [svpwm_pkg::SIN_W-1:0] rom [SINE_TABLE_DEPTH];

   for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_tab
      localparam longint Q    = longint'(i) * 4;
      localparam longint QUAD = Q / SINE_TABLE_DEPTH;
      localparam longint REM  = Q % SINE_TABLE_DEPTH;
      localparam longint U0   = (REM <<< 30) / SINE_TABLE_DEPTH;
      localparam longint U    = ((QUAD % 2) == 1) ? svpwm_pkg::Q30_ONE - U0 : U0;
      localparam longint M    = svpwm_pkg::quarter_sine(U);
      localparam longint V    = (QUAD >= 2) ? -M : M;
      assign rom[i] = svpwm_pkg::SIN_W'(V);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_a_ff <= rom[addr_a];
         data_b_ff <= rom[addr_b];
      end
   end

endmodule

[sv/svpwm_isqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_isqrt
// Pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module svpwm_isqrt #(
   parameter int IN_W   = svpwm_pkg::SQ_W,
   parameter int SIDE_W = $bits(svpwm_pkg::svpwm_side_type)
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [IN_W-1:0] in_value,
   input  logic [SIDE_W-1:0] in_side,
   output logic out_valid,
   output logic [IN_W/2-1:0] out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int RT_W  = IN_W / 2;
   localparam int RM_W  = RT_W + 1;
   localparam int ACC_W = RT_W + 3;

   logic [RM_W-1:0]   rem_ff  [RT_W];
   logic [RT_W-1:0]   root_ff [RT_W];
   logic [IN_W-1:0]   x_ff    [RT_W];
   logic [SIDE_W-1:0] side_ff [RT_W];
   logic [RT_W-1:0]   vld_ff;

   logic [RM_W-1:0]   rem_prev  [RT_W];
   logic [RT_W-1:0]   root_prev [RT_W];
   logic [IN_W-1:0]   x_prev    [RT_W];
   logic [SIDE_W-1:0] side_prev [RT_W];
   logic [RT_W-1:0]   vld_prev;

   for (genvar g = 0; g < RT_W; g++) begin : g_stage
      logic [ACC_W-1:0] acc;
      logic [ACC_W-1:0] trial;
      logic [RM_W-1:0]  rem_in;
      logic [RT_W-1:0]  root_in;

      if (g == 0) begin : g_first
         assign rem_prev[g]  = '0;
         assign root_prev[g] = '0;
         assign x_prev[g]    = in_value;
         assign side_prev[g] = in_side;
         assign vld_prev[g]  = in_valid;
      end else begin : g_next
         assign rem_prev[g]  = rem_ff[g-1];
         assign root_prev[g] = root_ff[g-1];
         assign x_prev[g]    = x_ff[g-1];
         assign side_prev[g] = side_ff[g-1];
         assign vld_prev[g]  = vld_ff[g-1];
      end

      always_comb begin
         acc   = {rem_prev[g], x_prev[g][IN_W-1 -: 2]};
         trial = ACC_W'({root_prev[g], 2'b01});
         if (acc >= trial) begin
            rem_in  = RM_W'(acc - trial);
            root_in = {root_prev[g][RT_W-2:0], 1'b1};
         end else begin
            rem_in  = RM_W'(acc);
            root_in = {root_prev[g][RT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_prev[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= rem_in;
            root_ff[g] <= root_in;
            x_ff[g]    <= x_prev[g] << 2;
            side_ff[g] <= side_prev[g];
         end
      end
   end

   assign out_valid = vld_ff[RT_W-1];
   assign out_root  = root_ff[RT_W-1];
   assign out_side  = side_ff[RT_W-1];

endmodule

[sv/svpwm_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_divider
// Pipelined restoring divider with overflow flag, one quotient bit per stage
// ----------------------------------------------------------------------------
module svpwm_divider #(
   parameter int NUM_W  = svpwm_pkg::NUM_W,
   parameter int DEN_W  = svpwm_pkg::DATA_W,
   parameter int Q_W    = svpwm_pkg::DATA_W,
   parameter int SIDE_W = $bits(svpwm_pkg::svpwm_side_type)
) (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic out_valid,
   output logic [Q_W-1:0] out_quot,
   output logic out_ovf,
   output logic [SIDE_W-1:0] out_side
);

   localparam int R_W = DEN_W + Q_W;

   logic [R_W-1:0]    rem_ff  [Q_W+1];
   logic [Q_W-1:0]    quot_ff [Q_W+1];
   logic              ovf_ff  [Q_W+1];
   logic [SIDE_W-1:0] side_ff [Q_W+1];
   logic [Q_W:0]      vld_ff;

   logic ovf_in;

   // quotient overflows when the numerator reaches den * 2^q
   assign ovf_in = in_num >= NUM_W'({in_den, Q_W'(0)});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= R_W'(in_num);
         quot_ff[0] <= '0;
         ovf_ff[0]  <= ovf_in;
         side_ff[0] <= in_side;
      end
   end

   for (genvar g = 1; g <= Q_W; g++) begin : g_stage
      localparam int BIT = Q_W - g;
      logic [R_W-1:0] dsh;
      logic [R_W-1:0] rem_in;
      logic [Q_W-1:0] quot_in;

      always_comb begin
         dsh     = R_W'(in_den) << BIT;
         rem_in  = rem_ff[g-1];
         quot_in = quot_ff[g-1];
         if (rem_ff[g-1] >= dsh) begin
            rem_in       = rem_ff[g-1] - dsh;
            quot_in[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_ff[g-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= rem_in;
            quot_ff[g] <= quot_in;
            ovf_ff[g]  <= ovf_ff[g-1];
            side_ff[g] <= side_ff[g-1];
         end
      end
   end

   assign out_valid = vld_ff[Q_W];
   assign out_quot  = quot_ff[Q_W];
   assign out_ovf   = ovf_ff[Q_W];
   assign out_side  = side_ff[Q_W];

endmodule

[sv/svpwm_duty_from_dq_voltage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_duty_from_dq_voltage
// Inverse park rotation and space vector duty mapping to three compare values
// ----------------------------------------------------------------------------
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/ready   | volt_q, volt_d, elec_angle
//  rsp     | out       | rsp_valid/ready   | compare_a/b/c, sector_number
//  csr     | in        | csr_valid/ready   | index, data
//
//  one item per cycle while no result is held; 5 front stages, 25 root stages,
//  17 divider stages, 3 duty and scaling stages
//  reset clears valid bits and registers to 1200 / 100
//  a held result stalls the whole pipe in place, nothing lost or repeated
// ----------------------------------------------------------------------------
module svpwm_duty_from_dq_voltage #(
   parameter int ANGLE_BITS       = svpwm_pkg::ANGLE_BITS_DEF,
   parameter int SINE_TABLE_DEPTH = svpwm_pkg::SINE_DEPTH_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [15:0] req_volt_q,
   input  logic signed [15:0] req_volt_d,
   input  logic [15:0] req_elec_angle,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [15:0] rsp_compare_a,
   output logic [15:0] rsp_compare_b,
   output logic [15:0] rsp_compare_c,
   output logic [2:0] rsp_sector_number,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [svpwm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0] csr_data
);

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
   localparam int MUL_W = ANGLE_BITS + 14;
   localparam int SW    = svpwm_pkg::SIN_W;
   localparam int PW    = svpwm_pkg::PROD_W;
   localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

   logic adv;
   logic [15:0] supply_ff;
   logic [15:0] period_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff <= svpwm_pkg::SUPPLY_RESET;
         period_ff <= svpwm_pkg::PERIOD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            svpwm_pkg::REG_SUPPLY: supply_ff <= csr_data;
            svpwm_pkg::REG_PERIOD: period_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // front: angle, table indices, sector
   logic [ANGLE_BITS-1:0] angle_ext;
   logic [ANGLE_BITS-1:0] theta_in;
   logic [ANGLE_BITS-1:0] theta_c;
   logic [MUL_W-1:0]      idx_s_mul;
   logic [MUL_W-1:0]      idx_c_mul;
   logic [ANGLE_BITS+2:0] six_mul;
   logic [ANGLE_BITS-1:0] frac;
   logic [ANGLE_BITS:0]   frac_left;
   logic [MUL_W-1:0]      p1_mul;
   logic [MUL_W-1:0]      p2_mul;
   logic [33:0]           p1_div;
   logic [33:0]           p2_div;

   if (ANGLE_BITS >= 16) begin : g_up
      assign angle_ext = ANGLE_BITS'(req_elec_angle) << (ANGLE_BITS - 16);
   end else begin : g_dn
      assign angle_ext = ANGLE_BITS'(req_elec_angle >> (16 - ANGLE_BITS));
   end

   always_comb begin
      theta_in  = angle_ext + QUARTER;
      theta_c   = theta_in + QUARTER;
      idx_s_mul = MUL_W'(theta_in) * MUL_W'(SINE_TABLE_DEPTH);
      idx_c_mul = MUL_W'(theta_c) * MUL_W'(SINE_TABLE_DEPTH);
      six_mul   = (ANGLE_BITS + 3)'(theta_in) * (ANGLE_BITS + 3)'(6);
      frac      = six_mul[ANGLE_BITS-1:0];
      frac_left = {1'b1, ANGLE_BITS'(0)} - {1'b0, frac};
      p1_mul    = MUL_W'(frac_left) * MUL_W'(SINE_TABLE_DEPTH);
      p2_mul    = MUL_W'(frac) * MUL_W'(SINE_TABLE_DEPTH);
      // divide by three through a reciprocal, exact below 2^17
      p1_div    = 34'(17'(p1_mul >> (ANGLE_BITS + 1))) * 34'(43691);
      p2_div    = 34'(17'(p2_mul >> (ANGLE_BITS + 1))) * 34'(43691);
   end

   // stage 1
   logic              s1_vld_ff;
   logic signed [15:0] s1_vq_ff, s1_vd_ff;
   logic [IDX_W-1:0]  s1_idx_s_ff, s1_idx_c_ff, s1_p1_ff, s1_p2_ff;
   logic [2:0]        s1_sector_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_vq_ff     <= req_volt_q;
         s1_vd_ff     <= req_volt_d;
         s1_idx_s_ff  <= IDX_W'(idx_s_mul >> ANGLE_BITS);
         s1_idx_c_ff  <= IDX_W'(idx_c_mul >> ANGLE_BITS);
         s1_p1_ff     <= IDX_W'(p1_div >> 17);
         s1_p2_ff     <= IDX_W'(p2_div >> 17);
         s1_sector_ff <= six_mul[ANGLE_BITS+2:ANGLE_BITS] + 3'd1;
      end
   end

   // stage 2: table reads
   logic signed [SW-1:0] sin_s, sin_c, sin_1, sin_2;
   logic              s2_vld_ff;
   logic signed [15:0] s2_vq_ff, s2_vd_ff;
   logic [2:0]        s2_sector_ff;

   svpwm_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom_park (
      .clock(clock), .en(adv), .addr_a(s1_idx_s_ff), .addr_b(s1_idx_c_ff),
      .data_a_ff(sin_s), .data_b_ff(sin_c)
   );

   svpwm_sine_rom #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_rom_sect (
      .clock(clock), .en(adv), .addr_a(s1_p1_ff), .addr_b(s1_p2_ff),
      .data_a_ff(sin_1), .data_b_ff(sin_2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_vq_ff     <= s1_vq_ff;
         s2_vd_ff     <= s1_vd_ff;
         s2_sector_ff <= s1_sector_ff;
      end
   end

   // stage 3: rotation products and sector gains
   logic [35:0] k1_mul, k2_mul;
   logic [16:0] sin_1p, sin_2p;
   logic        s3_vld_ff;
   logic signed [PW-1:0] s3_dc_ff, s3_qs_ff, s3_ds_ff, s3_qc_ff;
   svpwm_pkg::svpwm_side_type s3_side_ff;

   always_comb begin
      sin_1p = sin_1[SW-1] ? 17'd0 : sin_1[16:0];
      sin_2p = sin_2[SW-1] ? 17'd0 : sin_2[16:0];
      k1_mul = 36'(svpwm_pkg::SQRT3_Q16) * 36'(sin_1p) + 36'd32768;
      k2_mul = 36'(svpwm_pkg::SQRT3_Q16) * 36'(sin_2p) + 36'd32768;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_dc_ff          <= PW'(s2_vd_ff) * PW'(sin_c);
         s3_qs_ff          <= PW'(s2_vq_ff) * PW'(sin_s);
         s3_ds_ff          <= PW'(s2_vd_ff) * PW'(sin_s);
         s3_qc_ff          <= PW'(s2_vq_ff) * PW'(sin_c);
         s3_side_ff.k1     <= svpwm_pkg::K_W'(k1_mul >> 16);
         s3_side_ff.k2     <= svpwm_pkg::K_W'(k2_mul >> 16);
         s3_side_ff.sector <= s2_sector_ff;
      end
   end

   // stage 4: alpha, beta magnitudes rounded to q8
   logic signed [PW:0] alpha_raw, beta_raw;
   logic [PW:0]        alpha_abs, beta_abs;
   logic               s4_vld_ff;
   logic [svpwm_pkg::AMAG_W-1:0] s4_aa_ff, s4_bb_ff;
   svpwm_pkg::svpwm_side_type s4_side_ff;

   always_comb begin
      alpha_raw = (PW + 1)'(s3_dc_ff) - (PW + 1)'(s3_qs_ff);
      beta_raw  = (PW + 1)'(s3_ds_ff) + (PW + 1)'(s3_qc_ff);
      alpha_abs = alpha_raw[PW] ? -alpha_raw : alpha_raw;
      beta_abs  = beta_raw[PW] ? -beta_raw : beta_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (adv) begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s4_aa_ff   <= svpwm_pkg::AMAG_W'((alpha_abs + (PW + 1)'(128)) >> 8);
         s4_bb_ff   <= svpwm_pkg::AMAG_W'((beta_abs + (PW + 1)'(128)) >> 8);
         s4_side_ff <= s3_side_ff;
      end
   end

   // stage 5: squares
   logic s5_vld_ff;
   logic [svpwm_pkg::SQ_W-1:0] s5_aa_sq_ff, s5_bb_sq_ff;
   svpwm_pkg::svpwm_side_type s5_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (adv) begin
         s5_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_aa_sq_ff <= svpwm_pkg::SQ_W'(s4_aa_ff) * svpwm_pkg::SQ_W'(s4_aa_ff);
         s5_bb_sq_ff <= svpwm_pkg::SQ_W'(s4_bb_ff) * svpwm_pkg::SQ_W'(s4_bb_ff);
         s5_side_ff  <= s4_side_ff;
      end
   end

   // magnitude
   logic rt_vld;
   logic [svpwm_pkg::ROOT_W-1:0] rt_mag;
   svpwm_pkg::svpwm_side_type rt_side;

   svpwm_isqrt #(
      .IN_W(svpwm_pkg::SQ_W), .SIDE_W($bits(svpwm_pkg::svpwm_side_type))
   ) u_isqrt (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(s5_vld_ff), .in_value(s5_aa_sq_ff + s5_bb_sq_ff), .in_side(s5_side_ff),
      .out_valid(rt_vld), .out_root(rt_mag), .out_side(rt_side)
   );

   // modulation ratio
   logic dv_vld;
   logic [15:0] dv_quot;
   logic dv_ovf;
   svpwm_pkg::svpwm_side_type dv_side;

   svpwm_divider #(
      .NUM_W(svpwm_pkg::NUM_W), .DEN_W(16), .Q_W(16),
      .SIDE_W($bits(svpwm_pkg::svpwm_side_type))
   ) u_div (
      .clock(clock), .reset(reset), .en(adv),
      .in_valid(rt_vld), .in_num({rt_mag, 8'd0}), .in_den(supply_ff), .in_side(rt_side),
      .out_valid(dv_vld), .out_quot(dv_quot), .out_ovf(dv_ovf), .out_side(dv_side)
   );

   // stage t: active times
   logic [15:0] uref;
   logic [33:0] t1_mul, t2_mul;
   logic        st_vld_ff;
   logic [svpwm_pkg::T_W-1:0] st_t1_ff, st_t2_ff;
   logic [2:0]  st_sector_ff;

   always_comb begin
      uref = (dv_ovf || dv_quot > svpwm_pkg::UREF_MAX) ? svpwm_pkg::UREF_MAX : dv_quot;
      t1_mul = 34'(dv_side.k1) * 34'(uref) + 34'd32768;
      t2_mul = 34'(dv_side.k2) * 34'(uref) + 34'd32768;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_vld_ff <= 1'b0;
      end else if (adv) begin
         st_vld_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_t1_ff     <= svpwm_pkg::T_W'(t1_mul >> 16);
         st_t2_ff     <= svpwm_pkg::T_W'(t2_mul >> 16);
         st_sector_ff <= dv_side.sector;
      end
   end

   // stage m: sector mapping
   logic [svpwm_pkg::SUM_W-1:0] sum;
   logic [svpwm_pkg::SUM_W-1:0] t0;
   logic [svpwm_pkg::TA_W-1:0]  half, t1e, t2e, sume;
   logic [svpwm_pkg::TA_W-1:0]  ta_in, tb_in, tc_in;
   logic sm_vld_ff;
   logic [svpwm_pkg::TA_W-1:0] sm_ta_ff, sm_tb_ff, sm_tc_ff;
   logic [2:0] sm_sector_ff;

   always_comb begin
      sum  = svpwm_pkg::SUM_W'(st_t1_ff) + svpwm_pkg::SUM_W'(st_t2_ff);
      t0   = (sum > 18'd65536) ? '0 : 18'd65536 - sum;
      half = svpwm_pkg::TA_W'(t0 >> 1);
      t1e  = svpwm_pkg::TA_W'(st_t1_ff);
      t2e  = svpwm_pkg::TA_W'(st_t2_ff);
      sume = svpwm_pkg::TA_W'(sum);
      case (st_sector_ff)
         svpwm_pkg::SECT_1: begin
            ta_in = sume + half; tb_in = t2e + half; tc_in = half;
         end
         svpwm_pkg::SECT_2: begin
            ta_in = t1e + half; tb_in = sume + half; tc_in = half;
         end
         svpwm_pkg::SECT_3: begin
            ta_in = half; tb_in = sume + half; tc_in = t2e + half;
         end
         svpwm_pkg::SECT_4: begin
            ta_in = half; tb_in = t1e + half; tc_in = sume + half;
         end
         svpwm_pkg::SECT_5: begin
            ta_in = t2e + half; tb_in = half; tc_in = sume + half;
         end
         default: begin
            ta_in = sume + half; tb_in = half; tc_in = t1e + half;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_vld_ff <= 1'b0;
      end else if (adv) begin
         sm_vld_ff <= st_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sm_ta_ff     <= ta_in;
         sm_tb_ff     <= tb_in;
         sm_tc_ff     <= tc_in;
         sm_sector_ff <= st_sector_ff;
      end
   end

   // output stage: scale to the timer period
   logic [34:0] ca_mul, cb_mul, cc_mul;
   logic [18:0] ca_sh, cb_sh, cc_sh;
   logic        rsp_valid_ff;
   logic [15:0] rsp_a_ff, rsp_b_ff, rsp_c_ff;
   logic [2:0]  rsp_sector_ff;

   always_comb begin
      ca_mul = 35'(sm_ta_ff) * 35'(period_ff) + 35'd32768;
      cb_mul = 35'(sm_tb_ff) * 35'(period_ff) + 35'd32768;
      cc_mul = 35'(sm_tc_ff) * 35'(period_ff) + 35'd32768;
      ca_sh  = ca_mul[34:16];
      cb_sh  = cb_mul[34:16];
      cc_sh  = cc_mul[34:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= sm_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_a_ff      <= (ca_sh > 19'd65535) ? 16'hFFFF : ca_sh[15:0];
         rsp_b_ff      <= (cb_sh > 19'd65535) ? 16'hFFFF : cb_sh[15:0];
         rsp_c_ff      <= (cc_sh > 19'd65535) ? 16'hFFFF : cc_sh[15:0];
         rsp_sector_ff <= sm_sector_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_compare_a     = rsp_a_ff;
   assign rsp_compare_b     = rsp_b_ff;
   assign rsp_compare_c     = rsp_c_ff;
   assign rsp_sector_number = rsp_sector_ff;

endmodule

[sv/svpwm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_checker
// Port level checks for the space vector duty pipe
// ----------------------------------------------------------------------------
module svpwm_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [15:0] rsp_compare_a,
   input logic [15:0] rsp_compare_b,
   input logic [15:0] rsp_compare_c,
   input logic [2:0] rsp_sector_number
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_compare_a)
         && $stable(rsp_compare_b) && $stable(rsp_compare_c)
         && $stable(rsp_sector_number))
      else $error("result changed while stalled");

   a_sector: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sector_number >= 3'd1 && rsp_sector_number <= 3'd6)
      else $error("sector out of range");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input refused with empty output");

endmodule

bind svpwm_duty_from_dq_voltage svpwm_checker u_svpwm_checker (.*);

[verif/tb_svpwm_duty_from_dq_voltage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_svpwm_duty_from_dq_voltage
// Self-checking bench for the space vector duty pipe. A directed table under the
// reset settings and random d/q/angle commands under several bus voltage and
// period settings run with random request gaps and random response stalls. Each
// response is checked in order against a bit-true duty predictor or a fixed duty.
// ----------------------------------------------------------------------------
module tb_svpwm_duty_from_dq_voltage;

   localparam int  ANG_BITS   = 16;
   localparam int  SIN_DEPTH  = 256;
   localparam longint ONE_Q30 = 64'sd1073741824;
   localparam int  IDLE_LIMIT = 20000;
   localparam int  PHASE_ITEMS = 180;

   typedef struct packed {
      logic [15:0] cmp_a;
      logic [15:0] cmp_b;
      logic [15:0] cmp_c;
      logic [2:0]  sector;
   } duty_type;

   typedef struct {
      logic signed [15:0] vq;
      logic signed [15:0] vd;
      logic [15:0] angle;
      bit          typed;
      duty_type    duty;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_volt_q = '0;
   logic signed [15:0] req_volt_d = '0;
   logic [15:0] req_elec_angle = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_compare_a, rsp_compare_b, rsp_compare_c;
   logic [2:0]  rsp_sector_number;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [svpwm_pkg::CSR_IDX_W-1:0] csr_index = svpwm_pkg::REG_SUPPLY;
   logic [15:0] csr_data = '0;

   logic [15:0] bus_volt = svpwm_pkg::SUPPLY_RESET;
   logic [15:0] period   = svpwm_pkg::PERIOD_RESET;
   duty_type duty_expect_q[$];
   bit       cur_typed = 0;
   duty_type cur_duty;
   int       errors = 0;
   int       idle_cycles = 0;

   svpwm_duty_from_dq_voltage u_top (.*);

   always #4 clock = ~clock;

   // odd polynomial on the quarter wave, q30 in, q16 out
   function automatic longint poly_sine(longint u);
      longint c[5];
      longint u2, acc;
      c = '{64'sd1686629713, -64'sd693598668, 64'sd85569305, -64'sd5026992,
            64'sd172273};
      u2  = (u * u) / ONE_Q30;
      acc = c[4];
      for (int k = 3; k >= 0; k--) acc = c[k] + (acc * u2) / ONE_Q30;
      acc = (acc * u) / ONE_Q30;
      if (acc < 0) acc = 0;
      if (acc > ONE_Q30) acc = ONE_Q30;
      return (acc + 8192) >>> 14;
   endfunction

   function automatic longint sine_at(longint idx);
      longint q, quad, rem, u, m;
      q    = (idx % SIN_DEPTH) * 4;
      quad = q / SIN_DEPTH;
      rem  = q % SIN_DEPTH;
      u    = (rem << 30) / SIN_DEPTH;
      if (quad % 2 == 1) u = ONE_Q30 - u;
      m = poly_sine(u);
      return (quad >= 2) ? -m : m;
   endfunction

   function automatic longint root_floor(longint v);
      longint r;
      r = 0;
      for (longint b = 64'sd1 <<< 31; b > 0; b = b >>> 1)
         if ((r + b) * (r + b) <= v) r = r + b;
      return r;
   endfunction

   function automatic longint round_q8(longint x);
      return (x + (x < 0 ? -128 : 128)) / 256;
   endfunction

   function automatic logic [15:0] to_compare(longint t);
      longint c;
      c = (t * period + 32768) >>> 16;
      return (c > 65535) ? 16'hFFFF : c[15:0];
   endfunction

   function automatic duty_type predict_duty(logic signed [15:0] vq_in,
                                             logic signed [15:0] vd_in,
                                             logic [15:0] ang);
      longint turn, theta, s, c, vq, vd, al, be, mag, uref, sect, r;
      longint k1, k2, t1, t2, sum, t0, half, ta, tb, tc;
      duty_type o;
      turn  = 64'sd1 <<< ANG_BITS;
      vq    = vq_in;
      vd    = vd_in;
      theta = (ang + (turn >>> 2)) % turn;
      s  = sine_at((theta * SIN_DEPTH) >>> ANG_BITS);
      c  = sine_at((((theta + (turn >>> 2)) % turn) * SIN_DEPTH) >>> ANG_BITS);
      al = round_q8(vd * c - vq * s);
      be = round_q8(vd * s + vq * c);
      mag = root_floor(al * al + be * be);
      uref = (bus_volt == 0) ? svpwm_pkg::UREF_MAX : (mag <<< 8) / bus_volt;
      if (uref > svpwm_pkg::UREF_MAX) uref = svpwm_pkg::UREF_MAX;
      sect = (theta * 6) >>> ANG_BITS;
      r    = theta * 6 - sect * turn;
      sect = sect + 1;
      s  = sine_at(((turn - r) * SIN_DEPTH) / (6 * turn));
      c  = sine_at((r * SIN_DEPTH) / (6 * turn));
      k1 = (svpwm_pkg::SQRT3_Q16 * (s < 0 ? 0 : s) + 32768) >>> 16;
      k2 = (svpwm_pkg::SQRT3_Q16 * (c < 0 ? 0 : c) + 32768) >>> 16;
      t1 = (k1 * uref + 32768) >>> 16;
      t2 = (k2 * uref + 32768) >>> 16;
      sum  = t1 + t2;
      t0   = (sum > 65536) ? 0 : 65536 - sum;
      half = t0 >>> 1;
      case (sect)
         1: begin ta = sum + half; tb = t2 + half;  tc = half;       end
         2: begin ta = t1 + half;  tb = sum + half; tc = half;       end
         3: begin ta = half;       tb = sum + half; tc = t2 + half;  end
         4: begin ta = half;       tb = t1 + half;  tc = sum + half; end
         5: begin ta = t2 + half;  tb = half;       tc = sum + half; end
         default: begin ta = sum + half; tb = half; tc = t1 + half;  end
      endcase
      o.cmp_a  = to_compare(ta);
      o.cmp_b  = to_compare(tb);
      o.cmp_c  = to_compare(tc);
      o.sector = sect[2:0];
      return o;
   endfunction

   // request transfers: store the expected duty
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         duty_expect_q.push_back(cur_typed ? cur_duty
                                 : predict_duty(req_volt_q, req_volt_d, req_elec_angle));
   end

   // response transfers: compare in order
   always @(posedge clock) begin
      duty_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (duty_expect_q.size() == 0) begin
            $error("response with nothing expected");
            errors++;
         end else begin
            e = duty_expect_q.pop_front();
            if (rsp_compare_a !== e.cmp_a) begin
               $error("compare_a exp %0d got %0d", e.cmp_a, rsp_compare_a); errors++;
            end
            if (rsp_compare_b !== e.cmp_b) begin
               $error("compare_b exp %0d got %0d", e.cmp_b, rsp_compare_b); errors++;
            end
            if (rsp_compare_c !== e.cmp_c) begin
               $error("compare_c exp %0d got %0d", e.cmp_c, rsp_compare_c); errors++;
            end
            if (rsp_sector_number !== e.sector) begin
               $error("sector_number exp %0d got %0d", e.sector, rsp_sector_number);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side stalls
   initial begin
      int n;
      forever begin
         @(negedge clock);
         rsp_ready = 1'b1;
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
         repeat (n - 1) @(negedge clock);
         n = gap_len();
         if (n > 0) begin
            @(negedge clock);
            rsp_ready = 1'b0;
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_cmd(logic signed [15:0] vq, logic signed [15:0] vd,
                           logic [15:0] ang, bit typed, duty_type d);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid = 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid      = 1'b1;
      req_volt_q     = vq;
      req_volt_d     = vd;
      req_elec_angle = ang;
      cur_typed      = typed;
      cur_duty       = d;
      forever begin
         @(posedge clock);
         if (req_ready) break;
         @(negedge clock);
      end
      @(negedge clock);
   endtask

   task automatic write_csr(logic [svpwm_pkg::CSR_IDX_W-1:0] idx, logic [15:0] val);
      req_valid = 1'b0;
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
         @(negedge clock);
      end
      if (idx == svpwm_pkg::REG_SUPPLY) bus_volt = val;
      else period = val;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (duty_expect_q.size() != 0) @(negedge clock);
   endtask

   function automatic duty_type dz(logic [2:0] sect);
      duty_type d;
      d.cmp_a = 16'd50; d.cmp_b = 16'd50; d.cmp_c = 16'd50; d.sector = sect;
      return d;
   endfunction

   initial begin
      dir_row_type rows[$];
      logic [15:0] vols[5];
      logic [15:0] pers[5];
      logic signed [15:0] vq, vd;
      duty_type none;
      none = '0;
      vols = '{svpwm_pkg::SUPPLY_RESET, 16'd0, 16'd65535, 16'd1, 16'd0};
      pers = '{svpwm_pkg::PERIOD_RESET, 16'd65535, 16'd1, 16'd0, 16'd0};
      vols[4] = 16'($urandom_range(100, 5000));
      pers[4] = 16'($urandom_range(1, 65535));
      // zero command under reset settings: 50 percent on every phase
      rows.push_back('{16'sd0, 16'sd0, 16'd0,     1, dz(3'd2)});
      rows.push_back('{16'sd0, 16'sd0, 16'd65535, 1, dz(3'd2)});
      rows.push_back('{16'sd0, 16'sd0, 16'd16384, 1, dz(3'd4)});
      rows.push_back('{16'sd0, 16'sd0, 16'd32768, 1, dz(3'd5)});
      rows.push_back('{16'sd0, 16'sd0, 16'd49152, 1, dz(3'd1)});
      rows.push_back('{16'sd32767, 16'sd0, 16'd0, 0, none});
      rows.push_back('{-16'sd32768, 16'sd0, 16'd0, 0, none});
      rows.push_back('{16'sd0, 16'sd32767, 16'd21845, 0, none});
      rows.push_back('{16'sd0, -16'sd32768, 16'd43690, 0, none});
      rows.push_back('{16'sd32767, 16'sd32767, 16'd10923, 0, none});
      rows.push_back('{-16'sd32768, -16'sd32768, 16'd54613, 0, none});
      rows.push_back('{16'sd300, 16'sd100, 16'd5461, 0, none});
      rows.push_back('{16'sd300, 16'sd100, 16'd27306, 0, none});
      rows.push_back('{-16'sd200, 16'sd250, 16'd38229, 0, none});
      rows.push_back('{16'sd1, -16'sd1, 16'd60074, 0, none});
      rows.push_back('{16'sd692, 16'sd0, 16'd1, 0, none});

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i])
         send_cmd(rows[i].vq, rows[i].vd, rows[i].angle, rows[i].typed, rows[i].duty);

      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) begin
            drain();
            write_csr(svpwm_pkg::REG_SUPPLY, vols[ph]);
            write_csr(svpwm_pkg::REG_PERIOD, pers[ph]);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 9) < 4) begin
               vq = $signed(16'($urandom_range(0, 3000))) - 16'sd1500;
               vd = $signed(16'($urandom_range(0, 3000))) - 16'sd1500;
            end else begin
               vq = 16'($urandom);
               vd = 16'($urandom);
            end
            send_cmd(vq, vd, 16'($urandom), 0, none);
         end
      end

      drain();
      repeat (60) @(posedge clock);
      if (errors == 0 && duty_expect_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
